>>> hw/rtl/first_fit_range_allocator_macros.svh
// ----------------------------------------------------------------------------
// first_fit_range_allocator_macros
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH

// a holds now -> b holds in the same cycle
`define FFRA_ASSERT_NOW(label, a, b, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) else $error(msg);

// a holds now -> b holds in the next cycle
`define FFRA_ASSERT_NEXT(label, a, b, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) else $error(msg);

`endif

>>> hw/rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Types, codes and constants of the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int unsigned MAX_RANGES_DEF = 64;
    localparam int unsigned PAGE_BYTES_DEF = 4096;

    localparam logic [63:0] WINDOW_FIRST_BYTE = 64'hFFFF_9000_0000_0000;
    localparam logic [63:0] WINDOW_LAST_BYTE  = 64'hFFFF_9FFF_FFFF_FFFF;
    localparam logic [32:0] PAGES_CAP         = 33'h1_0000_0000;

    localparam int unsigned IN_DATA_W  = 112;
    localparam int unsigned OUT_DATA_W = 144;
    localparam int unsigned CFG_DATA_W = 52;

    // register indexes
    localparam logic [0:0] CFG_BASE_PAGE = 1'b0;
    localparam logic [0:0] CFG_PAGES     = 1'b1;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    // cell update modes
    localparam logic [2:0] M_NONE   = 3'd0;
    localparam logic [2:0] M_REMOVE = 3'd1;
    localparam logic [2:0] M_SHRINK = 3'd2;
    localparam logic [2:0] M_PREV   = 3'd3;
    localparam logic [2:0] M_BOTH   = 3'd4;
    localparam logic [2:0] M_NEXT   = 3'd5;
    localparam logic [2:0] M_INSERT = 3'd6;

    typedef struct packed {
        logic [31:0] start;
        logic [32:0] len;
    } t_range;

    typedef struct packed {
        logic       cmp;
        logic       upd;
        logic       reload;
        logic       action;
        logic [2:0] mode;
    } t_cell_ctl;

    function automatic logic [32:0] clamp_pages(input logic [32:0] v);
        logic [32:0] r;
        r = v;
        if (v == 33'd0) r = 33'd1;
        else if (v > PAGES_CAP) r = PAGES_CAP;
        return r;
    endfunction

endpackage

>>> hw/rtl/ffra_cell.sv
// ----------------------------------------------------------------------------
// ffra_cell
// One slot of the sorted free-range row: compare, first-hit chain, shift.
// ----------------------------------------------------------------------------
module ffra_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 7,
    parameter int unsigned REL_W = 52,
    parameter int unsigned PG_W  = 34
) (
    input  logic                i_clk,
    input  ffra_pkg::t_cell_ctl i_ctl,
    input  logic [CNT_W-1:0]    i_count,
    input  logic [REL_W-1:0]    i_rel,
    input  logic [REL_W:0]      i_rel_end,
    input  logic [PG_W-1:0]     i_pages,
    input  logic [32:0]         i_window_pages,
    input  ffra_pkg::t_range    i_left,
    input  ffra_pkg::t_range    i_right,
    input  logic                i_right_first,
    input  logic                i_seen,
    output ffra_pkg::t_range    o_range,
    output logic                o_seen_chain,
    output logic                o_first,
    output logic                o_adj_next,
    output logic                o_adj_prev
);
    import ffra_pkg::*;

    t_range      r_range, n_range;
    logic        r_first, r_seen, r_adj_next, r_adj_prev;
    logic        valid, flag, first_d;
    logic [33:0] range_end;
    logic [32:0] pg33;
    logic [31:0] rel32;

    assign valid     = (CNT_W'(IDX) < i_count);
    assign range_end = {1'b0, r_range.start} + {1'b0, r_range.len};
    assign pg33      = 33'(i_pages);
    assign rel32     = 32'(i_rel);

    // free: first slot at or above the freed start (or past the end)
    // allocate: first valid slot long enough
    always_comb begin
        if (i_ctl.action) begin
            flag = !valid || (64'(r_range.start) >= 64'(i_rel));
        end else begin
            flag = valid && (64'(r_range.len) >= 64'(i_pages));
        end
    end

    assign o_seen_chain = flag | i_seen;
    assign first_d      = flag & ~i_seen;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_first    <= first_d;
            r_seen     <= o_seen_chain;
            r_adj_next <= first_d & valid & (64'(r_range.start) == 64'(i_rel_end));
            r_adj_prev <= (64'(range_end) == 64'(i_rel));
        end
    end

    always_comb begin
        n_range = r_range;
        if (i_ctl.reload) begin
            n_range.start = 32'd0;
            n_range.len   = (IDX == 0) ? i_window_pages : 33'd0;
        end else if (i_ctl.upd) begin
            case (i_ctl.mode)
                M_REMOVE: begin
                    if (r_seen) n_range = i_right;
                end
                M_SHRINK: begin
                    if (r_first) begin
                        n_range.start = r_range.start + 32'(pg33);
                        n_range.len   = r_range.len - pg33;
                    end
                end
                M_PREV: begin
                    if (i_right_first) n_range.len = r_range.len + pg33;
                end
                M_BOTH: begin
                    if (i_right_first) n_range.len = r_range.len + pg33 + i_right.len;
                    else if (r_seen) n_range = i_right;
                end
                M_NEXT: begin
                    if (r_first) begin
                        n_range.start = rel32;
                        n_range.len   = r_range.len + pg33;
                    end
                end
                M_INSERT: begin
                    if (r_first) begin
                        n_range.start = rel32;
                        n_range.len   = pg33;
                    end else if (r_seen) begin
                        n_range = i_left;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_range <= n_range;
    end

    assign o_range    = r_range;
    assign o_first    = r_first;
    assign o_adj_next = r_adj_next;
    assign o_adj_prev = r_adj_prev;

endmodule

>>> hw/rtl/first_fit_range_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit page range allocator with coalescing over a row of range cells.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------
//  s stream | in        | i_s_tvalid / o_s_tready | i_s_tdata, i_s_tuser
//  m stream | out       | o_m_tvalid / i_m_tready | o_m_tdata
//  config   | in        | i_cfg_wr_en             | i_cfg_index, i_cfg_wdata
//
// An item goes through accept, parallel compare with the first-hit chain
// through the cells, decision, and one shift/update step of the cell row.
// The next item is taken while the result waits in the output register; after
// its update step the control holds only while that register is still full.
// Reset and every config write reload the row as one whole-window range.
// ----------------------------------------------------------------------------
module first_fit_range_allocator #(
    parameter int unsigned MAX_RANGES = ffra_pkg::MAX_RANGES_DEF,
    parameter int unsigned PAGE_BYTES = ffra_pkg::PAGE_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [0:0]                        i_cfg_index,
    input  logic [ffra_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // request_bytes[44:0], free_address[108:45], zero fill
    input  logic [ffra_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // action[0]
    input  logic [0:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // granted_address[63:0], status[65:64], free_range_count[72:66],
    // allocated_pages[105:73], free_pages[138:106], zero fill
    output logic [ffra_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import ffra_pkg::*;
    `include "first_fit_range_allocator_macros.svh"

    localparam int unsigned PG_SH = $clog2(PAGE_BYTES);
    localparam int unsigned REL_W = 64 - PG_SH;
    localparam int unsigned PG_W  = 46 - PG_SH;
    localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

    localparam logic [63:0] BASE_RAW = WINDOW_FIRST_BYTE >> PG_SH;
    localparam logic [51:0] BASE_RST = BASE_RAW[51:0];
    localparam logic [63:0] WP_RAW   = (WINDOW_LAST_BYTE - WINDOW_FIRST_BYTE + 64'd1) >> PG_SH;
    localparam logic [32:0] WP_RST   = clamp_pages(WP_RAW[32:0]);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;

    logic [2:0]       r_state;
    logic [51:0]      r_base;
    logic [32:0]      r_wp;
    logic [CNT_W-1:0] r_count;
    logic [32:0]      r_pa, r_pf;

    logic             r_action;
    logic [PG_W-1:0]  r_pages;
    logic [REL_W-1:0] r_rel;
    logic [REL_W:0]   r_rel_end;
    logic             r_oow, r_tail;

    logic [2:0]       r_mode;
    logic [1:0]       r_status;
    logic [63:0]      r_granted;
    logic [CNT_W-1:0] r_cnt_n;
    logic [32:0]      r_pa_n, r_pf_n;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic        reload, accept, slot_free, load_out;
    logic [32:0] wp_load;
    logic [51:0] base_load;
    logic [63:0] base64, base_bytes, addr;
    logic [45:0] bytes_up;
    logic [REL_W-1:0] rel_in;
    t_cell_ctl   ctl;

    t_range               rng   [MAX_RANGES];
    logic [MAX_RANGES-1:0] first, adjn_c, adjp_c, right_first;
    logic [MAX_RANGES:0]   seen;

    // ---- configuration and reload
    assign reload = !i_rst_n || i_cfg_wr_en;

    always_comb begin
        base_load = r_base;
        wp_load   = r_wp;
        if (!i_rst_n) begin
            base_load = BASE_RST;
            wp_load   = WP_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_BASE_PAGE) base_load = i_cfg_wdata;
            else wp_load = clamp_pages(i_cfg_wdata[32:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= base_load;
        r_wp   <= wp_load;
    end

    // ---- input stage
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign base64     = {12'd0, r_base};
    assign base_bytes = base64 << PG_SH;
    assign addr       = i_s_tdata[108:45];
    assign bytes_up   = {1'b0, i_s_tdata[44:0]} + 46'(PAGE_BYTES - 1);
    assign rel_in     = addr[63:PG_SH] - base64[REL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= i_s_tuser[0];
            r_pages   <= bytes_up[45:PG_SH];
            r_rel     <= rel_in;
            r_rel_end <= {1'b0, rel_in} + (REL_W + 1)'(bytes_up[45:PG_SH]);
        end
        if (r_state == S_CMP) begin
            r_oow  <= (64'(r_rel) >= 64'(r_wp)) ||
                      (64'(r_pages) > (64'(r_wp) - 64'(r_rel)));
            // free lands past the last cell when no cell claims it
            r_tail <= r_action & ~seen[MAX_RANGES];
        end
    end

    // ---- cell row
    assign ctl.cmp    = (r_state == S_CMP);
    assign ctl.upd    = (r_state == S_UPD);
    assign ctl.reload = reload;
    assign ctl.action = r_action;
    assign ctl.mode   = r_mode;
    assign seen[0]    = 1'b0;

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        t_range left_rng, right_rng;
        if (g == 0) begin : g_l0
            assign left_rng = '0;
        end else begin : g_ln
            assign left_rng = rng[g-1];
        end
        if (g == MAX_RANGES - 1) begin : g_rl
            assign right_rng      = '0;
            assign right_first[g] = r_tail;
        end else begin : g_rn
            assign right_rng      = rng[g+1];
            assign right_first[g] = first[g+1];
        end

        ffra_cell #(
            .IDX   (g),
            .CNT_W (CNT_W),
            .REL_W (REL_W),
            .PG_W  (PG_W)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (ctl),
            .i_count        (r_count),
            .i_rel          (r_rel),
            .i_rel_end      (r_rel_end),
            .i_pages        (r_pages),
            .i_window_pages (wp_load),
            .i_left         (left_rng),
            .i_right        (right_rng),
            .i_right_first  (right_first[g]),
            .i_seen         (seen[g]),
            .o_range        (rng[g]),
            .o_seen_chain   (seen[g+1]),
            .o_first        (first[g]),
            .o_adj_next     (adjn_c[g]),
            .o_adj_prev     (adjp_c[g])
        );
    end

    // ---- decision
    logic        any_first, exact, adj_next, adj_prev;
    logic [31:0] gstart;
    logic [2:0]  d_mode;
    logic [1:0]  d_status;
    logic [63:0] d_granted;
    logic [CNT_W-1:0] d_cnt;
    logic [32:0] d_pa, d_pf;
    logic [37:0] pa_sum, pf_sum;

    always_comb begin
        any_first = 1'b0;
        exact     = 1'b0;
        adj_next  = 1'b0;
        adj_prev  = 1'b0;
        gstart    = 32'd0;
        for (int i = 0; i < MAX_RANGES; i++) begin
            any_first = any_first | first[i];
            exact     = exact | (first[i] & (64'(rng[i].len) == 64'(r_pages)));
            gstart    = gstart | (first[i] ? rng[i].start : 32'd0);
            adj_next  = adj_next | adjn_c[i];
            adj_prev  = adj_prev | (adjp_c[i] & right_first[i]);
        end
    end

    assign pa_sum = 38'(r_pa) + 38'(r_pages);
    assign pf_sum = 38'(r_pf) + 38'(r_pages);

    always_comb begin
        d_mode    = M_NONE;
        d_status  = ST_OK;
        d_granted = 64'd0;
        d_cnt     = r_count;
        d_pa      = r_pa;
        d_pf      = r_pf;
        if (r_pages == '0) begin
            d_status = ST_ZERO;
        end else if (!r_action) begin
            if (!any_first) begin
                d_status = ST_NOFIT;
            end else begin
                d_granted = base_bytes + (64'(gstart) << PG_SH);
                d_mode    = exact ? M_REMOVE : M_SHRINK;
                d_cnt     = exact ? r_count - CNT_W'(1) : r_count;
                d_pa      = (pa_sum > 38'(r_wp)) ? r_wp : pa_sum[32:0];
                d_pf      = (38'(r_pf) > 38'(r_pages)) ? 33'(38'(r_pf) - 38'(r_pages)) : 33'd0;
            end
        end else if (r_oow) begin
            d_status = ST_NOFIT;
        end else if (!adj_next && !adj_prev && (32'(r_count) >= 32'(MAX_RANGES))) begin
            d_status = ST_FULL;
        end else begin
            if (adj_prev && adj_next) begin
                d_mode = M_BOTH;
                d_cnt  = r_count - CNT_W'(1);
            end else if (adj_prev) begin
                d_mode = M_PREV;
            end else if (adj_next) begin
                d_mode = M_NEXT;
            end else begin
                d_mode = M_INSERT;
                d_cnt  = r_count + CNT_W'(1);
            end
            d_pa = (38'(r_pa) > 38'(r_pages)) ? 33'(38'(r_pa) - 38'(r_pages)) : 33'd0;
            d_pf = (pf_sum > 38'(r_wp)) ? r_wp : pf_sum[32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DEC) begin
            r_status  <= d_status;
            r_granted <= d_granted;
            r_cnt_n   <= d_cnt;
            r_pa_n    <= d_pa;
            r_pf_n    <= d_pf;
        end
    end

    // ---- control
    assign slot_free = !r_out_valid || i_m_tready;
    assign load_out  = slot_free && ((r_state == S_UPD) || (r_state == S_WAIT));

    always_ff @(posedge i_clk) begin
        if (reload) begin
            r_count <= CNT_W'(1);
            r_pa    <= 33'd0;
            r_pf    <= wp_load;
        end else if (r_state == S_UPD) begin
            r_count <= r_cnt_n;
            r_pa    <= r_pa_n;
            r_pf    <= r_pf_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_NONE;
        end else begin
            unique case (r_state)
                S_IDLE: if (accept) r_state <= S_CMP;
                S_CMP:  r_state <= S_DEC;
                S_DEC: begin
                    r_mode  <= d_mode;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_mode  <= M_NONE;
                    r_state <= slot_free ? S_IDLE : S_WAIT;
                end
                S_WAIT: if (slot_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            r_out_data <= {5'd0, r_pf_n, r_pa_n, 7'(r_cnt_n), r_status, r_granted};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // ---- assertions
    `FFRA_ASSERT_NOW(a_count_bounds, 1'b1, 32'(r_count) <= 32'(MAX_RANGES), "range count out of bounds")
    `FFRA_ASSERT_NEXT(a_accept_starts, accept, r_state == S_CMP, "accepted item did not start")
    `FFRA_ASSERT_NOW(a_zero_no_grant, r_out_valid && (r_out_data[65:64] == ST_ZERO),
        r_out_data[63:0] == 64'd0, "zero-size request returned an address")
    `FFRA_ASSERT_NOW(a_single_hit, r_state == S_DEC, $onehot0({r_tail, first}),
        "more than one first hit in the cell row")

endmodule
